/* rtl/hsl2rgb_pkg.sv */
`default_nettype none
package hsl2rgb_pkg;

  // full-scale channel value
  localparam logic [7:0] FULL_SCALE = 8'hFF;

  // hue sector, named by the two primaries it lies between
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage
`default_nettype wire

/* rtl/hsl2rgb_in_if.sv */
`default_nettype none
interface hsl2rgb_in_if #(
  parameter int FRAC_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS:0]   lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input lightness,
                output ready);
endinterface
`default_nettype wire

/* rtl/hsl2rgb_out_if.sv */
`default_nettype none
interface hsl2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

/* rtl/hsl_to_rgb_converter_top.sv */
`default_nettype none
// HSL to RGB converter. Takes one color per clock as hue (fraction of a turn),
// saturation and lightness (FRAC_BITS fraction bits, values above 1.0 clamp to
// 1.0) and returns 8-bit red, green and blue, rounded half up and saturated.
// The datapath is a five-stage pipeline: input clamp and sector split, chroma
// multiply, secondary multiply and offset, channel placement and sum, and the
// final scale to 255. Items enter and leave at one per clock while the output
// is ready. Each stage holds its own valid bit and loads when it is empty or
// the stage after it moves, so a stall on the output fills bubbles before it
// stops the input.
module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hsl2rgb_in_if.sink  in_ch,
  hsl2rgb_out_if.source out_ch
);
  import hsl2rgb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = 2 * F + 2;
  localparam logic [F:0]      ONE      = (F + 1)'(1) << F;
  localparam logic [F+1:0]    TWO_ONE  = (F + 2)'(1) << (F + 1);
  localparam logic [2*F+1:0]  HALF_C   = (2 * F + 2)'(1) << (F - 1);
  localparam logic [VW+8:0]   HALF_OUT = (VW + 9)'(1) << (2 * F - 1);

  // scale to 255 with round half up, saturate
  function automatic logic [7:0] to_byte(input logic [VW-1:0] v);
    logic [VW+8:0]        sc;
    logic [VW+8-2*F:0]    q;
    sc = {1'b0, v, 8'd0} - {9'd0, v} + HALF_OUT;
    q  = sc[VW+8:2*F];
    return (q > (VW + 9 - 2 * F)'(FULL_SCALE)) ? FULL_SCALE : q[7:0];
  endfunction

  // per-stage valid and load enables
  logic [4:0] v_r;
  logic [4:0] en;

  always_comb begin
    en[4] = !v_r[4] || out_ch.ready;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: clamp, hue times six, tent of lightness
  logic [F:0]   sat_c;
  logic [F:0]   lig_c;
  logic [F+2:0] h6;
  logic [F+1:0] two_l;
  logic [F+1:0] t_w;

  always_comb begin
    sat_c = (in_ch.saturation > ONE) ? ONE : in_ch.saturation;
    lig_c = (in_ch.lightness > ONE) ? ONE : in_ch.lightness;
    h6    = {1'b0, in_ch.hue, 2'b00} + {2'b00, in_ch.hue, 1'b0};
    two_l = {lig_c, 1'b0};
    t_w   = (two_l >= {1'b0, ONE}) ? TWO_ONE - two_l : two_l;
  end

  sector_t      s1_sector_r;
  logic [F-1:0] s1_frac_r;
  logic [F:0]   s1_t_r;
  logic [F:0]   s1_sat_r;
  logic [F:0]   s1_lig_r;

  always_ff @(posedge clk) begin
    if (en[0] && in_ch.valid) begin
      s1_sector_r <= sector_t'(h6[F+2:F]);
      s1_frac_r   <= h6[F-1:0];
      s1_t_r      <= t_w[F:0];
      s1_sat_r    <= sat_c;
      s1_lig_r    <= lig_c;
    end
  end

  // stage 1: chroma, rounded to F fraction bits, and sector weight
  logic [2*F+1:0] ts_prod;
  logic [2*F+1:0] c_full;
  logic [F:0]     w_nxt;

  always_comb begin
    ts_prod = s1_t_r * s1_sat_r;
    c_full  = (ts_prod + HALF_C) >> F;
    w_nxt   = s1_sector_r[0] ? ONE - {1'b0, s1_frac_r} : {1'b0, s1_frac_r};
  end

  sector_t    s2_sector_r;
  logic [F:0] s2_c_r;
  logic [F:0] s2_w_r;
  logic [F:0] s2_lig_r;

  always_ff @(posedge clk) begin
    if (en[1] && v_r[0]) begin
      s2_sector_r <= s1_sector_r;
      s2_c_r      <= c_full[F:0];
      s2_w_r      <= w_nxt;
      s2_lig_r    <= s1_lig_r;
    end
  end

  // stage 2: secondary component and offset m, clamped at zero
  logic [2*F+1:0] xw_full;
  logic [2*F:0]   lw;
  logic [2*F:0]   halfc;
  logic [2*F:0]   m_nxt;

  always_comb begin
    xw_full = s2_c_r * s2_w_r;
    lw      = {s2_lig_r, F'(0)};
    halfc   = {1'b0, s2_c_r, (F - 1)'(0)};
    m_nxt   = (lw > halfc) ? lw - halfc : '0;
  end

  sector_t      s3_sector_r;
  logic [2*F:0] s3_xw_r;
  logic [2*F:0] s3_cw_r;
  logic [2*F:0] s3_m_r;

  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      s3_sector_r <= s2_sector_r;
      s3_xw_r     <= xw_full[2*F:0];
      s3_cw_r     <= {s2_c_r, F'(0)};
      s3_m_r      <= m_nxt;
    end
  end

  // stage 3: place chroma and secondary by sector, add offset
  logic [2*F:0]  r_pl, g_pl, b_pl;
  logic [VW-1:0] r_sum, g_sum, b_sum;

  always_comb begin
    r_pl = '0;
    g_pl = '0;
    b_pl = '0;
    unique case (s3_sector_r)
      SEC_RED_YEL: begin r_pl = s3_cw_r; g_pl = s3_xw_r; end
      SEC_YEL_GRN: begin r_pl = s3_xw_r; g_pl = s3_cw_r; end
      SEC_GRN_CYN: begin g_pl = s3_cw_r; b_pl = s3_xw_r; end
      SEC_CYN_BLU: begin g_pl = s3_xw_r; b_pl = s3_cw_r; end
      SEC_BLU_MAG: begin r_pl = s3_xw_r; b_pl = s3_cw_r; end
      default:     begin r_pl = s3_cw_r; b_pl = s3_xw_r; end
    endcase
    r_sum = {1'b0, r_pl} + {1'b0, s3_m_r};
    g_sum = {1'b0, g_pl} + {1'b0, s3_m_r};
    b_sum = {1'b0, b_pl} + {1'b0, s3_m_r};
  end

  logic [VW-1:0] s4_r_r, s4_g_r, s4_b_r;

  always_ff @(posedge clk) begin
    if (en[3] && v_r[2]) begin
      s4_r_r <= r_sum;
      s4_g_r <= g_sum;
      s4_b_r <= b_sum;
    end
  end

  // stage 4: scale to bytes into the output register
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (en[4] && v_r[3]) begin
      red_r   <= to_byte(s4_r_r);
      green_r <= to_byte(s4_g_r);
      blue_r  <= to_byte(s4_b_r);
    end
  end

  assign out_ch.valid = v_r[4];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // checks
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output side is ready");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (s2_c_r <= ONE))
    else $error("chroma above one");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (s2_w_r <= ONE))
    else $error("sector weight above one");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && en[4]) |=> v_r[4])
    else $error("item lost between last two stages");

endmodule
`default_nettype wire

/* tb/sv/hsl_to_rgb_converter_top_tb.sv */
`timescale 1ns / 100ps

module hsl_to_rgb_converter_top_tb;
  import hsl2rgb_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] UNITY = 64'd1 << FRAC;
  localparam int RANDOM_ITEMS = 1230;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // expected colors in order of acceptance, checked against each result
  class rgb_scoreboard;
    rgb_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    // scale a channel sum with 2F fraction bits to 0..255, round half up
    function logic [7:0] to_channel_byte(logic [63:0] level);
      logic [63:0] scaled;
      scaled = (level * 64'd255 + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
      return (scaled > 64'(FULL_SCALE)) ? FULL_SCALE : scaled[7:0];
    endfunction

    function rgb_t predict_rgb(logic [FRAC-1:0] hue, logic [FRAC:0] sat_in,
                               logic [FRAC:0] lig_in);
      logic [63:0] sat, lig, h6, pos, lig_dist, tone, chroma, weight;
      logic [63:0] c_full, x_full, l_full, half_c, offset;
      logic [63:0] r_sum, g_sum, b_sum;
      sector_t sec;
      rgb_t color;
      sat = (64'(sat_in) > UNITY) ? UNITY : 64'(sat_in);
      lig = (64'(lig_in) > UNITY) ? UNITY : 64'(lig_in);
      // six sectors per turn, position within sector as a fraction
      h6 = 64'(hue) * 64'd6;
      sec = sector_t'(h6[FRAC+2:FRAC]);
      pos = h6 & (UNITY - 64'd1);
      // chroma from lightness distance to one half
      lig_dist = (2 * lig >= UNITY) ? 2 * lig - UNITY : UNITY - 2 * lig;
      tone = UNITY - lig_dist;
      chroma = (tone * sat + (UNITY >> 1)) >> FRAC;
      weight = sec[0] ? UNITY - pos : pos;
      c_full = chroma << FRAC;
      x_full = chroma * weight;
      l_full = lig << FRAC;
      half_c = chroma << (FRAC - 1);
      offset = (l_full > half_c) ? l_full - half_c : 64'd0;
      // place chroma and secondary by sector
      case (sec)
        SEC_RED_YEL: begin r_sum = c_full; g_sum = x_full; b_sum = 0; end
        SEC_YEL_GRN: begin r_sum = x_full; g_sum = c_full; b_sum = 0; end
        SEC_GRN_CYN: begin r_sum = 0; g_sum = c_full; b_sum = x_full; end
        SEC_CYN_BLU: begin r_sum = 0; g_sum = x_full; b_sum = c_full; end
        SEC_BLU_MAG: begin r_sum = x_full; g_sum = 0; b_sum = c_full; end
        default: begin r_sum = c_full; g_sum = 0; b_sum = x_full; end
      endcase
      color.red = to_channel_byte(r_sum + offset);
      color.green = to_channel_byte(g_sum + offset);
      color.blue = to_channel_byte(b_sum + offset);
      return color;
    endfunction

    function void note_input(logic [FRAC-1:0] hue, logic [FRAC:0] sat, logic [FRAC:0] lig);
      expected_q.push_back(predict_rgb(hue, sat, lig));
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      logic [2:0][7:0] want_ch, got_ch;
      string chan_name[3];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      want_ch = want;
      got_ch = got;
      chan_name = '{"red", "green", "blue"};
      for (int i = 0; i < 3; i++) begin
        if (want_ch[2-i] !== got_ch[2-i]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan_name[i],
                   want_ch[2-i], got_ch[2-i]);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit steady;
  int unsigned stall_cycles;
  int unsigned directed_sent;
  int unsigned random_sent;
  int unsigned clamped_sent;
  rgb_scoreboard sb = new();

  hsl2rgb_in_if #(.FRAC_BITS(FRAC)) in_ch ();
  hsl2rgb_out_if out_ch ();

  hsl_to_rgb_converter_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    rst_n = 1'b0;
    steady = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.hue = '0;
    in_ch.saturation = '0;
    in_ch.lightness = '0;
    out_ch.ready = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.hue, in_ch.saturation, in_ch.lightness);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{out_ch.red, out_ch.green, out_ch.blue});
      end
    end
  end

  // stop if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("[hsl_to_rgb_converter_top] ERROR");
        $finish;
      end
    end
  end

  // offer one item, holding it until taken
  task automatic send_hsl(input logic [FRAC-1:0] hue, input logic [FRAC:0] sat,
                          input logic [FRAC:0] lig);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.hue <= hue;
    in_ch.saturation <= sat;
    in_ch.lightness <= lig;
    if (64'(sat) > UNITY || 64'(lig) > UNITY) clamped_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the input until every expected color is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_directed(input logic [FRAC-1:0] hue, input logic [FRAC:0] sat,
                               input logic [FRAC:0] lig);
    send_hsl(hue, sat, lig);
    directed_sent++;
  endtask

  // random color, biased toward sector edges, clamping and lightness extremes
  task automatic send_random();
    logic [FRAC-1:0] hue;
    logic [FRAC:0] sat, lig;
    int sec;
    hue = FRAC'($urandom_range(65535));
    sat = (FRAC + 1)'($urandom_range(65536));
    lig = (FRAC + 1)'($urandom_range(65536));
    case ($urandom_range(9))
      0: begin
        sec = $urandom_range(5);
        hue = FRAC'((sec * 65536 + 5) / 6 + $urandom_range(6) - 3);
      end
      1: sat = (FRAC + 1)'($urandom_range(131071, 65537));
      2: lig = (FRAC + 1)'($urandom_range(131071, 65537));
      3: begin
        case ($urandom_range(3))
          0: lig = '0;
          1: lig = (FRAC + 1)'(UNITY);
          default: lig = (FRAC + 1)'(32768 + $urandom_range(8) - 4);
        endcase
      end
      4: sat = $urandom_range(1) ? (FRAC + 1)'(UNITY) : '0;
      default: ;
    endcase
    send_hsl(hue, sat, lig);
    random_sent++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // black, white, grey and full-saturation red
    send_directed(16'd0, 17'd0, 17'd0);
    send_directed(16'd0, 17'd65536, 17'd65536);
    send_directed(16'd12345, 17'd0, 17'd32768);
    send_directed(16'd0, 17'd65536, 17'd32768);
    // each sector start, the last hue before it and the top of the range
    send_directed(16'd10922, 17'd65536, 17'd32768);
    send_directed(16'd10923, 17'd65536, 17'd32768);
    send_directed(16'd21845, 17'd65536, 17'd32768);
    send_directed(16'd21846, 17'd65536, 17'd32768);
    send_directed(16'd32767, 17'd65536, 17'd32768);
    send_directed(16'd32768, 17'd65536, 17'd32768);
    send_directed(16'd43690, 17'd65536, 17'd32768);
    send_directed(16'd43691, 17'd65536, 17'd32768);
    send_directed(16'd54613, 17'd65536, 17'd32768);
    send_directed(16'd54614, 17'd65536, 17'd32768);
    send_directed(16'd65535, 17'd65536, 17'd32768);
    // saturation and lightness above one clamp
    send_directed(16'd20000, 17'd131071, 17'd40000);
    send_directed(16'd50000, 17'd30000, 17'd131071);
    send_directed(16'd65535, 17'd131071, 17'd131071);
    // tiny lightness at full saturation, offset clamps at zero; then near-full saturation at high lightness
    send_directed(16'd30000, 17'd65536, 17'd1);
    send_directed(16'd5000, 17'd65535, 17'd65535);
    send_directed(16'd40000, 17'd65535, 17'd49151);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 700);
      if (n == 900) wait_drained();
      send_random();
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    // let the pipeline empty
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random colors, %0d with clamped inputs",
             directed_sent, random_sent, clamped_sent);
    $display("compared %0d results with %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[hsl_to_rgb_converter_top] OK");
    end else begin
      $display("[hsl_to_rgb_converter_top] ERROR");
    end
    $finish;
  end

endmodule
